/* hdl/glyph_box_width_splitter_macros.svh */
// ----------------------------------------------------------------------------
// Glyph box width splitter assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off while in reset.
// ----------------------------------------------------------------------------
`ifndef GLYPH_BOX_WIDTH_SPLITTER_MACROS_SVH
`define GLYPH_BOX_WIDTH_SPLITTER_MACROS_SVH

// Same-cycle implication.
`define GBWS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GBWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/gbws_pkg.sv */
// ----------------------------------------------------------------------------
// Glyph box width splitter package
// Widths, command and state codes, and control structs shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package gbws_pkg;

  localparam int COORD_BITS = 12;
  localparam int MAX_BOXES  = 65535;
  localparam int MAX_PARTS  = 64;
  localparam int MIN_SPLIT  = 2;

  localparam int SUM_W   = 28;
  localparam int CNT_W   = $clog2(MAX_BOXES + 1);
  localparam int PARTS_W = $clog2(MAX_PARTS + 1);
  localparam int DIV_W   = SUM_W;
  localparam int STEP_W  = $clog2(DIV_W + 1);
  localparam int TDATA_W = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int IUSER_W = 2;
  localparam int OUSER_W = 2;

  typedef enum logic [1:0] {
    CMD_ACC   = 2'd0,
    CMD_SPLIT = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_AVG,
    ST_DIV_QUO,
    ST_DIV_PART,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    DSEL_AVG,
    DSEL_QUO,
    DSEL_PART
  } dsel_e;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic             in_fire;
    logic [1:0]       cmd;
    logic             count_zero;
    logic             div_done;
    logic             quo_zero;
    logic             quo_lt_min;
    logic             slot_free;
    logic             last_slice;
  } gbws_stat_t;

  // Controls from the sequencer to the datapath.
  typedef struct packed {
    logic  in_ready;
    logic  acc_en;
    logic  clr_en;
    logic  div_start;
    dsel_e div_sel;
    logic  single_load;
    logic  noavg;
    logic  slices_load;
    logic  sw_load;
    logic  emit_en;
  } gbws_ctrl_t;

endpackage

`default_nettype wire

/* hdl/gbws_divider.sv */
// ----------------------------------------------------------------------------
// Glyph box width splitter divider
// Restoring divider, one quotient bit per cycle, step count chosen per start.
// ----------------------------------------------------------------------------
`default_nettype none

module gbws_divider
  import gbws_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [STEP_W-1:0] steps_i,
  input  wire logic [DIV_W-1:0]  dividend_i,
  input  wire logic [DIV_W-1:0]  divisor_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [DIV_W-1:0]       quo_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DIV_W-1:0]  dvs_q, dvs_d;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              fits;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = steps_i;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

/* hdl/gbws_fsm.sv */
// ----------------------------------------------------------------------------
// Glyph box width splitter sequencer
// Steps one split item through up to three divisions and the slice emission,
// and applies accumulate and clear commands.
`default_nettype none

module gbws_fsm
  import gbws_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire gbws_stat_t stat_i,
  output gbws_ctrl_t      ctrl_o,
  output state_e          state_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (stat_i.in_fire && (stat_i.cmd == CMD_SPLIT)) begin
          state_d = stat_i.count_zero ? ST_EMIT : ST_DIV_AVG;
        end
      end
      ST_DIV_AVG: begin
        if (stat_i.div_done) begin
          state_d = stat_i.quo_zero ? ST_EMIT : ST_DIV_QUO;
        end
      end
      ST_DIV_QUO: begin
        if (stat_i.div_done) begin
          state_d = stat_i.quo_lt_min ? ST_EMIT : ST_DIV_PART;
        end
      end
      ST_DIV_PART: begin
        if (stat_i.div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.slot_free && stat_i.last_slice) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    ctrl_o.div_sel = DSEL_AVG;
    case (state_q)
      ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        if (stat_i.in_fire) begin
          case (stat_i.cmd)
            CMD_ACC:   ctrl_o.acc_en = 1'b1;
            CMD_CLEAR: ctrl_o.clr_en = 1'b1;
            CMD_SPLIT: begin
              if (stat_i.count_zero) begin
                ctrl_o.single_load = 1'b1;
                ctrl_o.noavg       = 1'b1;
              end else begin
                ctrl_o.div_start = 1'b1;
                ctrl_o.div_sel   = DSEL_AVG;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV_AVG: begin
        if (stat_i.div_done) begin
          if (stat_i.quo_zero) begin
            ctrl_o.single_load = 1'b1;
            ctrl_o.noavg       = 1'b1;
          end else begin
            ctrl_o.div_start = 1'b1;
            ctrl_o.div_sel   = DSEL_QUO;
          end
        end
      end
      ST_DIV_QUO: begin
        if (stat_i.div_done) begin
          if (stat_i.quo_lt_min) begin
            ctrl_o.single_load = 1'b1;
          end else begin
            ctrl_o.div_start   = 1'b1;
            ctrl_o.div_sel     = DSEL_PART;
            ctrl_o.slices_load = 1'b1;
          end
        end
      end
      ST_DIV_PART: begin
        ctrl_o.sw_load = stat_i.div_done;
      end
      ST_EMIT: begin
        ctrl_o.emit_en = stat_i.slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

`default_nettype wire

/* hdl/glyph_box_width_splitter.sv */
// ----------------------------------------------------------------------------
// Glyph box width splitter
// Averages glyph box widths and cuts wide boxes into equal-width slices.
// ----------------------------------------------------------------------------
// Input stream: tuser carries the command (accumulate, split, clear), tlast
// the word-end flag, tdata the box edges. Each split item yields one output
// item per slice on the output stream; tlast marks the final slice of a box.
// Accumulate, clear and unused commands yield nothing.
// A split runs on one shared restoring divider, one quotient bit a cycle:
// average = sum / count (28 steps), quotient = width / average (12 steps),
// slice width = width / slices (12 steps). Slices then leave one per cycle
// while the receiver takes them (n slices, n at most 64); the split item
// ends early with a single slice when there is no average or the quotient
// is below 2.
// The input is not ready while a split is in flight. The output register
// holds an item while tready is low and the sequencer waits on it; the next
// input item can be accepted while the last slice still waits there.
// Reset clears the width sum, the box count, the sequencer and the output
// valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_box_width_splitter
  import gbws_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // left_x, top_y, right_x, bottom_y from bit 0 up
  input  wire logic [TDATA_W-1:0] s_axis_tdata_i,
  // cmd
  input  wire logic [IUSER_W-1:0] s_axis_tuser_i,
  // word_end
  input  wire logic               s_axis_tlast_i,
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  // out_left_x, out_top_y, out_right_x, out_bottom_y from bit 0 up
  output logic [TDATA_W-1:0]      m_axis_tdata_o,
  // out_word_end, no_average from bit 0 up
  output logic [OUSER_W-1:0]      m_axis_tuser_o,
  // last_part
  output logic                    m_axis_tlast_o
);

  localparam int CB = COORD_BITS;
  localparam int PAD_W = DIV_W - CB;
  localparam logic [PARTS_W-1:0] MAX_PARTS_V = PARTS_W'(MAX_PARTS);
  localparam logic [CNT_W-1:0]   MAX_BOXES_V = CNT_W'(MAX_BOXES);

  gbws_stat_t stat;
  gbws_ctrl_t ctrl;
  state_e     state;

  logic [CB-1:0] in_lx, in_ty, in_rx, in_by, in_w;
  logic          in_fire;

  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [SUM_W:0]     sum_add;

  logic [CB-1:0]      ty_q, rx_q, by_q, w_q, sw_q, left_q;
  logic               we_q;
  logic [PARTS_W-1:0] n_q, idx_q, parts;
  logic               noavg_q;

  logic [STEP_W-1:0]  div_steps;
  logic [DIV_W-1:0]   div_dividend, div_divisor, div_quo;
  logic               div_busy, div_done;
  logic               in_div_state;

  logic               out_valid_q;
  logic [CB-1:0]      o_lx_q, o_ty_q, o_rx_q, o_by_q;
  logic               o_last_q, o_we_q, o_noavg_q;
  logic               last_slice;

  assign in_lx   = s_axis_tdata_i[0*CB +: CB];
  assign in_ty   = s_axis_tdata_i[1*CB +: CB];
  assign in_rx   = s_axis_tdata_i[2*CB +: CB];
  assign in_by   = s_axis_tdata_i[3*CB +: CB];
  assign in_w    = (in_rx >= in_lx) ? (in_rx - in_lx) : '0;
  assign in_fire = s_axis_tvalid_i && (state == ST_IDLE);

  // Clamp the slice count to the limit.
  assign parts = (div_quo > DIV_W'(MAX_PARTS)) ? MAX_PARTS_V : div_quo[PARTS_W-1:0];
  assign last_slice = (idx_q == (n_q - PARTS_W'(1)));

  assign stat.in_fire    = in_fire;
  assign stat.cmd        = s_axis_tuser_i[1:0];
  assign stat.count_zero = (cnt_q == '0);
  assign stat.div_done   = div_done;
  assign stat.quo_zero   = (div_quo == '0);
  assign stat.quo_lt_min = (div_quo < DIV_W'(MIN_SPLIT));
  assign stat.slot_free  = !out_valid_q || m_axis_tready_i;
  assign stat.last_slice = last_slice;

  gbws_fsm u_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .state_o (state)
  );

  always_comb begin
    div_steps    = STEP_W'(DIV_W);
    div_dividend = sum_q;
    div_divisor  = DIV_W'(cnt_q);
    case (ctrl.div_sel)
      DSEL_AVG: begin
        div_steps    = STEP_W'(DIV_W);
        div_dividend = sum_q;
        div_divisor  = DIV_W'(cnt_q);
      end
      DSEL_QUO: begin
        // Dividend sits in the top bits so only CB steps are needed.
        div_steps    = STEP_W'(CB);
        div_dividend = {w_q, {PAD_W{1'b0}}};
        div_divisor  = div_quo;
      end
      DSEL_PART: begin
        div_steps    = STEP_W'(CB);
        div_dividend = {w_q, {PAD_W{1'b0}}};
        div_divisor  = DIV_W'(parts);
      end
      default: ;
    endcase
  end

  gbws_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl.div_start),
    .steps_i    (div_steps),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  // Running width sum and box count, both saturating.
  assign sum_add = {1'b0, sum_q} + (SUM_W + 1)'(in_w);

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (ctrl.clr_en) begin
      sum_d = '0;
      cnt_d = '0;
    end else if (ctrl.acc_en) begin
      sum_d = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      if (cnt_q != MAX_BOXES_V) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  // Box and slice working registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ty_q   <= in_ty;
      rx_q   <= in_rx;
      by_q   <= in_by;
      w_q    <= in_w;
      we_q   <= s_axis_tlast_i;
      left_q <= in_lx;
    end else if (ctrl.emit_en) begin
      left_q <= left_q + sw_q;
    end
    if (ctrl.single_load) begin
      n_q     <= PARTS_W'(1);
      noavg_q <= ctrl.noavg;
    end else if (ctrl.slices_load) begin
      n_q     <= parts;
      noavg_q <= 1'b0;
    end
    if (ctrl.single_load || ctrl.slices_load) begin
      idx_q <= '0;
    end else if (ctrl.emit_en) begin
      idx_q <= idx_q + PARTS_W'(1);
    end
    if (ctrl.sw_load) begin
      sw_q <= div_quo[CB-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit_en) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit_en) begin
      o_lx_q    <= left_q;
      o_ty_q    <= ty_q;
      o_rx_q    <= last_slice ? rx_q : (left_q + sw_q);
      o_by_q    <= by_q;
      o_last_q  <= last_slice;
      o_we_q    <= last_slice && we_q;
      o_noavg_q <= noavg_q;
    end
  end

  always_comb begin
    m_axis_tdata_o = '0;
    m_axis_tdata_o[0*CB +: CB] = o_lx_q;
    m_axis_tdata_o[1*CB +: CB] = o_ty_q;
    m_axis_tdata_o[2*CB +: CB] = o_rx_q;
    m_axis_tdata_o[3*CB +: CB] = o_by_q;
  end

  assign m_axis_tuser_o  = {o_noavg_q, o_we_q};
  assign m_axis_tlast_o  = o_last_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign s_axis_tready_o = ctrl.in_ready;

  assign in_div_state = (state == ST_DIV_AVG) || (state == ST_DIV_QUO) ||
                        (state == ST_DIV_PART);

`include "glyph_box_width_splitter_macros.svh"

  `GBWS_ASSERT_NOW(a_ready_div_idle, s_axis_tready_o, !div_busy, "ready while dividing")
  `GBWS_ASSERT_NOW(a_done_in_div, div_done, in_div_state, "divider done outside a division")
  `GBWS_ASSERT_NOW(a_noavg_single, m_axis_tvalid_o && m_axis_tuser_o[1], m_axis_tlast_o, "no-avg")
  `GBWS_ASSERT_NEXT(a_emit_fills, ctrl.emit_en, m_axis_tvalid_o, "emitted slice not presented")

endmodule

`default_nettype wire
